FILE: hw/rtl/grid_raymarch_column_renderer_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid ray-march column renderer
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_RAYMARCH_COLUMN_RENDERER_TOP_DEFINES_SVH
`define GRID_RAYMARCH_COLUMN_RENDERER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/grc_pkg.sv
// ---------------------------------------------------------------------------
// grc_pkg
// Shared constants, command/status types and tables of the column renderer.
// ---------------------------------------------------------------------------
package grc_pkg;

    localparam int MAP_SIZE       = 16;
    localparam int SCREEN_ROWS    = 40;
    localparam int MAX_STEPS      = 160;
    localparam int STEPS_PER_CELL = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WALLS_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALLS_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALLS_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALLS_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd5;

    localparam logic [14:0] FOV_RESET  = 15'd8192;
    localparam logic [7:0]  COLS_RESET = 8'd120;

    // shared radix-2 divider
    localparam int DIV_W     = 23;
    localparam int DIV_CNT_W = 5;

    // glyph codes
    localparam logic [3:0] GLYPH_BLANK  = 4'd0;
    localparam logic [3:0] GLYPH_FULL   = 4'd1;
    localparam logic [3:0] GLYPH_DARK   = 4'd2;
    localparam logic [3:0] GLYPH_MEDIUM = 4'd3;
    localparam logic [3:0] GLYPH_LIGHT  = 4'd4;
    localparam logic [3:0] GLYPH_HASH   = 4'd5;
    localparam logic [3:0] GLYPH_CROSS  = 4'd6;
    localparam logic [3:0] GLYPH_DASH   = 4'd7;
    localparam logic [3:0] GLYPH_DOT    = 4'd8;

    typedef struct packed {
        logic       load_in;
        logic       set_ray;
        logic       trig;
        logic       ee;
        logic       march;
        logic       edge_go;
        logic [1:0] edge_k;
        logic       sel;
        logic       div_shade;
        logic       set_ceil;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic march_stop;
        logic march_wall;
        logic last_row;
    } t_sts;

    // quarter-wave sine, Q1.12, entries 0..64
    function automatic logic [12:0] quarter_sine(input logic [6:0] idx);
        logic [12:0] v;
        case (idx)
            7'd0:  v = 13'd0;    7'd1:  v = 13'd101;  7'd2:  v = 13'd201;
            7'd3:  v = 13'd301;  7'd4:  v = 13'd401;  7'd5:  v = 13'd501;
            7'd6:  v = 13'd601;  7'd7:  v = 13'd700;  7'd8:  v = 13'd799;
            7'd9:  v = 13'd897;  7'd10: v = 13'd995;  7'd11: v = 13'd1092;
            7'd12: v = 13'd1189; 7'd13: v = 13'd1285; 7'd14: v = 13'd1380;
            7'd15: v = 13'd1474; 7'd16: v = 13'd1567; 7'd17: v = 13'd1660;
            7'd18: v = 13'd1751; 7'd19: v = 13'd1842; 7'd20: v = 13'd1931;
            7'd21: v = 13'd2019; 7'd22: v = 13'd2106; 7'd23: v = 13'd2191;
            7'd24: v = 13'd2276; 7'd25: v = 13'd2359; 7'd26: v = 13'd2440;
            7'd27: v = 13'd2520; 7'd28: v = 13'd2598; 7'd29: v = 13'd2675;
            7'd30: v = 13'd2751; 7'd31: v = 13'd2824; 7'd32: v = 13'd2896;
            7'd33: v = 13'd2967; 7'd34: v = 13'd3035; 7'd35: v = 13'd3102;
            7'd36: v = 13'd3166; 7'd37: v = 13'd3229; 7'd38: v = 13'd3290;
            7'd39: v = 13'd3349; 7'd40: v = 13'd3406; 7'd41: v = 13'd3461;
            7'd42: v = 13'd3513; 7'd43: v = 13'd3564; 7'd44: v = 13'd3612;
            7'd45: v = 13'd3659; 7'd46: v = 13'd3703; 7'd47: v = 13'd3745;
            7'd48: v = 13'd3784; 7'd49: v = 13'd3822; 7'd50: v = 13'd3857;
            7'd51: v = 13'd3889; 7'd52: v = 13'd3920; 7'd53: v = 13'd3948;
            7'd54: v = 13'd3973; 7'd55: v = 13'd3996; 7'd56: v = 13'd4017;
            7'd57: v = 13'd4036; 7'd58: v = 13'd4052; 7'd59: v = 13'd4065;
            7'd60: v = 13'd4076; 7'd61: v = 13'd4085; 7'd62: v = 13'd4091;
            7'd63: v = 13'd4095;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

    // sin^2 of the edge bounds in Q0.36
    function automatic logic [22:0] bound_sq(input logic [1:0] sel);
        logic [22:0] v;
        case (sel)
            2'd0:    v = 23'd6871719;
            2'd1:    v = 23'd1717973;
            2'd2:    v = 23'd274878;
            default: v = 23'd68719;
        endcase
        return v;
    endfunction

    // sine of a binary angle, Q1.12, interpolated on the low 8 bits
    function automatic logic signed [13:0] sine_of(input logic [15:0] a);
        logic [1:0]  q;
        logic [14:0] rr;
        logic [6:0]  i;
        logic [7:0]  f;
        logic [12:0] t0;
        logic [12:0] t1;
        logic [12:0] diff;
        logic [15:0] prod;
        logic [12:0] mag;
        q    = a[15:14];
        rr   = q[0] ? (15'h4000 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        i    = rr[14:8];
        f    = rr[7:0];
        t0   = quarter_sine(i);
        t1   = quarter_sine(i + 7'd1);
        diff = t1 - t0;
        prod = {9'd0, diff[6:0]} * {8'd0, f} + 16'd128;
        mag  = (i >= 7'd64) ? 13'd4096 : (t0 + {5'd0, prod[15:8]});
        return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

FILE: hw/rtl/grid_raymarch_column_renderer_top.sv
// ---------------------------------------------------------------------------
// grid_raymarch_column_renderer_top
// Renders one screen column per input transfer and sends 40 row transfers,
// top row first. The march takes n steps, n from 1 to 160; a wall hit adds
// the corner edge test, and the output can stall the rows. The march runs one
// step per cycle, and the column angle and the ceiling row each go through a
// shared radix-2 divider at one quotient bit per cycle (23 quotient bits).
// Row transfers go out at one per cycle unless the output is stalled; the
// next column is taken while the last row still waits in the output register.
// ---------------------------------------------------------------------------
module grid_raymarch_column_renderer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [grc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [15:0]                       i_pos_x,
    input  logic [15:0]                       i_pos_y,
    input  logic [15:0]                       i_view_angle,
    input  logic [7:0]                        i_column,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [5:0]                        o_row,
    output logic [3:0]                        o_glyph,
    output logic [7:0]                        o_hit_steps,
    output logic                              o_last
);

    grc_pkg::t_cmd cmd;
    grc_pkg::t_sts sts;

    // sequencer
    grc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    grc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_view_angle (i_view_angle),
        .i_column     (i_column),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_row        (o_row),
        .o_glyph      (o_glyph),
        .o_hit_steps  (o_hit_steps),
        .o_last       (o_last)
    );

endmodule

FILE: hw/rtl/grc_dpath.sv
// ---------------------------------------------------------------------------
// grc_dpath
// Datapath: config registers, shared divider, sine/cosine, march stepper,
// corner edge pipeline, row shading and the output register.
// ---------------------------------------------------------------------------
module grc_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [grc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [15:0]                       i_pos_x,
    input  logic [15:0]                       i_pos_y,
    input  logic [15:0]                       i_view_angle,
    input  logic [7:0]                        i_column,
    input  grc_pkg::t_cmd                     i_cmd,
    output grc_pkg::t_sts                     o_sts,
    output logic [5:0]                        o_row,
    output logic [3:0]                        o_glyph,
    output logic [7:0]                        o_hit_steps,
    output logic                              o_last
);

    // configuration
    logic [255:0] r_walls;
    logic [14:0]  r_fov;
    logic [7:0]   r_cols;

    // item
    logic [15:0] r_px;
    logic [15:0] r_py;
    logic [15:0] r_va;
    logic [15:0] r_ray;

    // divider
    logic [grc_pkg::DIV_W-1:0]     r_quo;
    logic [8:0]                    r_rem;
    logic [8:0]                    r_dvs;
    logic [grc_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic [9:0]                    rem_sh;
    logic                          rem_ge;
    logic [22:0]                   col_fov;
    logic [7:0]                    cols_eff;

    // direction and march
    logic signed [13:0] r_ex;
    logic signed [13:0] r_ey;
    logic [25:0]        r_ee;
    logic signed [27:0] sqe_x;
    logic signed [27:0] sqe_y;
    logic signed [27:0] ee_sum;
    logic signed [21:0] r_sx;
    logic signed [21:0] r_sy;
    logic [7:0]         r_n;
    logic [21:0]        px10;
    logic [21:0]        py10;
    logic signed [21:0] nx_sx;
    logic signed [21:0] nx_sy;
    logic [7:0]         nx_n;
    logic [16:0]        mx;
    logic [16:0]        my;
    logic [5:0]         cx_w;
    logic [5:0]         cy_w;
    logic               m_neg;
    logic               m_out;
    logic               m_wall;
    logic [9:0]         n10;

    // hit
    logic [7:0] r_steps;
    logic [3:0] r_cx;
    logic [3:0] r_cy;
    logic [1:0] r_sel;
    logic       r_edge;

    // edge pipeline
    logic [4:0]         ccx;
    logic [4:0]         ccy;
    logic signed [17:0] vx;
    logic signed [17:0] vy;
    logic               r_a_v;
    logic               r_b_v;
    logic               r_c_v;
    logic               r_d_v;
    logic [1:0]         r_a_k;
    logic [1:0]         r_b_k;
    logic [1:0]         r_c_k;
    logic [1:0]         r_d_k;
    logic signed [31:0] r_a_dx;
    logic signed [31:0] r_a_dy;
    logic signed [31:0] r_a_cx;
    logic signed [31:0] r_a_cy;
    logic signed [35:0] r_a_sx;
    logic signed [35:0] r_a_sy;
    logic signed [32:0] b_dot;
    logic signed [32:0] b_crs;
    logic [32:0]        b_abs;
    logic signed [35:0] b_vv;
    logic               r_b_pos;
    logic [29:0]        r_b_ac;
    logic [33:0]        r_b_vv;
    logic               r_c_pos;
    logic [59:0]        r_c_lhs;
    logic [59:0]        r_c_pe;
    logic [58:0]        d_rhs_full;
    logic               r_d_pos;
    logic [59:0]        r_d_lhs;
    logic [46:0]        r_d_rhs;
    logic               r_on [4];
    logic [33:0]        r_d2 [4];
    logic [1:0]         sa;
    logic [1:0]         sb;
    logic               sb_v;
    logic               edge_seen;

    // shading
    logic               r_neg;
    logic [7:0]         sh_diff;
    logic [13:0]        shade_num;
    logic signed [10:0] r_ceil;
    logic [3:0]         r_wglyph;
    logic [3:0]         wglyph;
    logic [9:0]         s10;
    logic [5:0]         r_row;
    logic signed [10:0] ys;
    logic signed [10:0] floor_row;
    logic [6:0]         rest;
    logic [11:0]        rest12;
    logic [3:0]         row_glyph;
    logic               row_last;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walls <= '0;
            r_fov   <= grc_pkg::FOV_RESET;
            r_cols  <= grc_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                grc_pkg::CFG_WALLS_0: r_walls[63:0]    <= i_cfg_data;
                grc_pkg::CFG_WALLS_1: r_walls[127:64]  <= i_cfg_data;
                grc_pkg::CFG_WALLS_2: r_walls[191:128] <= i_cfg_data;
                grc_pkg::CFG_WALLS_3: r_walls[255:192] <= i_cfg_data;
                grc_pkg::CFG_FOV:     r_fov            <= i_cfg_data[14:0];
                grc_pkg::CFG_COLS:    r_cols           <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // divider: one quotient bit per cycle
    assign cols_eff = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign col_fov  = {15'd0, i_column} * {8'd0, r_fov};
    assign rem_sh   = {r_rem, r_quo[grc_pkg::DIV_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.load_in || i_cmd.div_shade) begin
            r_dcnt <= grc_pkg::DIV_CNT_W'(grc_pkg::DIV_W);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_quo <= col_fov;
            r_rem <= '0;
            r_dvs <= {1'b0, cols_eff};
        end else if (i_cmd.div_shade) begin
            r_quo <= {9'd0, shade_num};
            r_rem <= '0;
            r_dvs <= {r_steps, 1'b0};
        end else if (r_dcnt != '0) begin
            r_rem <= rem_ge ? 9'(rem_sh - {1'b0, r_dvs}) : rem_sh[8:0];
            r_quo <= {r_quo[grc_pkg::DIV_W-2:0], rem_ge};
        end
    end

    // latch item, ray angle, direction
    assign sqe_x  = r_ex * r_ex;
    assign sqe_y  = r_ey * r_ey;
    assign ee_sum = sqe_x + sqe_y;
    assign px10   = {6'd0, r_px} * 22'd10;
    assign py10   = {6'd0, r_py} * 22'd10;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_va <= i_view_angle;
        end
        if (i_cmd.set_ray) begin
            r_ray <= r_va - {2'd0, r_fov[14:1]} + r_quo[15:0];
        end
        if (i_cmd.trig) begin
            r_ex <= grc_pkg::sine_of(r_ray);
            r_ey <= grc_pkg::sine_of(r_ray + 16'h4000);
        end
        if (i_cmd.ee) begin
            r_ee <= ee_sum[25:0];
        end
    end

    // march step: next point, its cell, and the stop test
    assign nx_sx  = r_sx + 22'(r_ex);
    assign nx_sy  = r_sy + 22'(r_ey);
    assign nx_n   = r_n + 8'd1;
    assign m_neg  = nx_sx[21] | nx_sy[21];
    assign mx     = {8'd0, nx_sx[20:12]} * 17'd205;
    assign my     = {8'd0, nx_sy[20:12]} * 17'd205;
    assign cx_w   = mx[16:11];
    assign cy_w   = my[16:11];
    assign m_out  = (cx_w >= 6'(grc_pkg::MAP_SIZE)) || (cy_w >= 6'(grc_pkg::MAP_SIZE));
    assign m_wall = r_walls[{cy_w[3:0], cx_w[3:0]}];
    assign n10    = {2'd0, nx_n};

    assign o_sts.march_wall = !m_neg && !m_out && m_wall;
    assign o_sts.march_stop = m_neg || m_out || m_wall
                              || (nx_n == 8'(grc_pkg::MAX_STEPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig) begin
            r_sx   <= $signed(px10);
            r_sy   <= $signed(py10);
            r_n    <= '0;
            r_edge <= 1'b0;
        end else if (i_cmd.march) begin
            r_sx <= nx_sx;
            r_sy <= nx_sy;
            r_n  <= nx_n;
            if (o_sts.march_stop) begin
                r_steps <= o_sts.march_wall ? nx_n : 8'(grc_pkg::MAX_STEPS);
                r_cx    <= cx_w[3:0];
                r_cy    <= cy_w[3:0];
                if ((n10 << 2) < 10'(grc_pkg::MAX_STEPS)) begin
                    r_sel <= 2'd0;
                end else if ((n10 << 1) < 10'(grc_pkg::MAX_STEPS)) begin
                    r_sel <= 2'd1;
                end else if (n10 < 10'(grc_pkg::MAX_STEPS)) begin
                    r_sel <= 2'd2;
                end else begin
                    r_sel <= 2'd3;
                end
            end
        end else if (i_cmd.sel) begin
            r_edge <= edge_seen;
        end
    end

    // corner vectors of the hit cell
    assign ccx = {1'b0, r_cx} + {4'd0, i_cmd.edge_k[1]};
    assign ccy = {1'b0, r_cy} + {4'd0, i_cmd.edge_k[0]};
    assign vx  = $signed({1'b0, ccx, 12'd0}) - $signed({2'd0, r_px});
    assign vy  = $signed({1'b0, ccy, 12'd0}) - $signed({2'd0, r_py});

    // edge pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= i_cmd.edge_go;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    assign b_dot = 33'(r_a_dx) + 33'(r_a_dy);
    assign b_crs = 33'(r_a_cx) - 33'(r_a_cy);
    assign b_abs = b_crs[32] ? 33'(-b_crs) : 33'(b_crs);
    assign b_vv  = r_a_sx + r_a_sy;
    assign d_rhs_full = r_c_pe[59:24] * grc_pkg::bound_sq(r_sel);

    // products, sums, squares, bound, compare: one stage each
    always_ff @(posedge i_clk) begin
        r_a_k  <= i_cmd.edge_k;
        r_a_dx <= r_ex * vx;
        r_a_dy <= r_ey * vy;
        r_a_cx <= r_ex * vy;
        r_a_cy <= r_ey * vx;
        r_a_sx <= vx * vx;
        r_a_sy <= vy * vy;

        r_b_k   <= r_a_k;
        r_b_pos <= !b_dot[32] && (b_dot != '0);
        r_b_ac  <= b_abs[29:0];
        r_b_vv  <= b_vv[33:0];

        r_c_k   <= r_b_k;
        r_c_pos <= r_b_pos;
        r_c_lhs <= r_b_ac * r_b_ac;
        r_c_pe  <= r_ee * r_b_vv;
        if (r_b_v) begin
            r_d2[r_b_k] <= r_b_vv;
        end

        r_d_k   <= r_c_k;
        r_d_pos <= r_c_pos;
        r_d_lhs <= r_c_lhs;
        r_d_rhs <= d_rhs_full[58:12];
        if (r_d_v) begin
            r_on[r_d_k] <= r_d_pos && (r_d_lhs < {13'd0, r_d_rhs});
        end
    end

    // nearest two corners among the first three, then among all four
    always_comb begin
        edge_seen = 1'b0;
        sa        = 2'd0;
        sb        = 2'd0;
        sb_v      = 1'b0;
        for (int m = 3; m <= 4; m++) begin
            sa = 2'd0;
            for (int k = 1; k < 4; k++) begin
                if (k < m && r_d2[k] < r_d2[sa]) begin
                    sa = 2'(k);
                end
            end
            sb   = 2'd0;
            sb_v = 1'b0;
            for (int k = 0; k < 4; k++) begin
                if (k < m && 2'(k) != sa && (!sb_v || r_d2[k] < r_d2[sb])) begin
                    sb   = 2'(k);
                    sb_v = 1'b1;
                end
            end
            if (r_on[sa] || r_on[sb]) begin
                edge_seen = 1'b1;
            end
        end
    end

    // ceiling row numerator and wall shade
    assign sh_diff   = (r_steps < 8'(2 * grc_pkg::STEPS_PER_CELL))
                       ? 8'(2 * grc_pkg::STEPS_PER_CELL) - r_steps
                       : r_steps - 8'(2 * grc_pkg::STEPS_PER_CELL);
    assign shade_num = {6'd0, sh_diff} * 14'(grc_pkg::SCREEN_ROWS);
    assign s10       = {2'd0, r_steps};

    always_comb begin
        if (r_edge) begin
            wglyph = grc_pkg::GLYPH_BLANK;
        end else if ((s10 << 2) <= 10'(grc_pkg::MAX_STEPS)) begin
            wglyph = grc_pkg::GLYPH_FULL;
        end else if (s10 * 10'd3 < 10'(grc_pkg::MAX_STEPS)) begin
            wglyph = grc_pkg::GLYPH_DARK;
        end else if ((s10 << 1) < 10'(grc_pkg::MAX_STEPS)) begin
            wglyph = grc_pkg::GLYPH_MEDIUM;
        end else if (s10 < 10'(grc_pkg::MAX_STEPS)) begin
            wglyph = grc_pkg::GLYPH_LIGHT;
        end else begin
            wglyph = grc_pkg::GLYPH_BLANK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_shade) begin
            r_neg <= r_steps < 8'(2 * grc_pkg::STEPS_PER_CELL);
        end
        if (i_cmd.set_ceil) begin
            r_ceil   <= r_neg ? -$signed({2'd0, r_quo[8:0]}) : $signed({2'd0, r_quo[8:0]});
            r_wglyph <= wglyph;
        end
    end

    // glyph of the current row
    assign ys        = $signed({5'd0, r_row});
    assign floor_row = 11'(grc_pkg::SCREEN_ROWS) - r_ceil;
    assign rest      = 7'(grc_pkg::SCREEN_ROWS) - {1'b0, r_row};
    assign rest12    = {5'd0, rest};
    assign row_last  = r_row == 6'(grc_pkg::SCREEN_ROWS - 1);

    always_comb begin
        if (ys < r_ceil) begin
            row_glyph = grc_pkg::GLYPH_BLANK;
        end else if (ys > r_ceil && ys <= floor_row) begin
            row_glyph = r_wglyph;
        end else if ((rest12 << 3) < 12'(grc_pkg::SCREEN_ROWS)) begin
            row_glyph = grc_pkg::GLYPH_HASH;
        end else if ((rest12 << 2) < 12'(grc_pkg::SCREEN_ROWS)) begin
            row_glyph = grc_pkg::GLYPH_CROSS;
        end else if ((rest12 << 3) < 12'(3 * grc_pkg::SCREEN_ROWS)) begin
            row_glyph = grc_pkg::GLYPH_DASH;
        end else if (rest12 * 12'd20 < 12'(9 * grc_pkg::SCREEN_ROWS)) begin
            row_glyph = grc_pkg::GLYPH_DOT;
        end else begin
            row_glyph = grc_pkg::GLYPH_BLANK;
        end
    end

    // advance row and load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_ceil) begin
            r_row <= '0;
        end else if (i_cmd.emit) begin
            r_row       <= r_row + 6'd1;
            o_row       <= r_row;
            o_glyph     <= row_glyph;
            o_hit_steps <= r_steps;
            o_last      <= row_last;
        end
    end

    assign o_sts.div_done = r_dcnt == '0;
    assign o_sts.last_row = row_last;

endmodule

FILE: hw/rtl/grc_ctrl.sv
// ---------------------------------------------------------------------------
// grc_ctrl
// Sequencer of one column: divide, trig, march, edge test, shade, emit rows.
// ---------------------------------------------------------------------------
`include "grid_raymarch_column_renderer_top_defines.svh"

module grc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  grc_pkg::t_sts i_sts,
    output grc_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVA  = 4'd1;
    localparam logic [3:0] S_ANGLE = 4'd2;
    localparam logic [3:0] S_TRIG  = 4'd3;
    localparam logic [3:0] S_EE    = 4'd4;
    localparam logic [3:0] S_MARCH = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_SEL   = 4'd7;
    localparam logic [3:0] S_DIVS  = 4'd8;
    localparam logic [3:0] S_CEIL  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    localparam logic [2:0] EDGE_LAST = 3'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_ecnt;
    logic       r_o_valid;
    logic       out_free;

    assign out_free = !r_o_valid || !i_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DIVA;
                end
            end
            S_DIVA: begin
                if (i_sts.div_done) n_state = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.set_ray = 1'b1;
                n_state       = S_TRIG;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state    = S_EE;
            end
            S_EE: begin
                o_cmd.ee = 1'b1;
                n_state  = S_MARCH;
            end
            S_MARCH: begin
                o_cmd.march = 1'b1;
                if (i_sts.march_stop) n_state = i_sts.march_wall ? S_EDGE : S_DIVS;
            end
            S_EDGE: begin
                o_cmd.edge_go = !r_ecnt[2];
                o_cmd.edge_k  = r_ecnt[1:0];
                if (r_ecnt == EDGE_LAST) n_state = S_SEL;
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_shade = 1'b1;
                n_state         = S_CEIL;
            end
            S_CEIL: begin
                if (i_sts.div_done) begin
                    o_cmd.set_ceil = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_row) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, corner counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ecnt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ecnt  <= (r_state == S_EDGE) ? r_ecnt + 3'd1 : 3'd0;
            if (o_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_o_valid;

    `GRC_ASSERT_NOW(a_emit_free, o_cmd.emit, out_free, "row emitted over a pending result")
    `GRC_ASSERT_NOW(a_done_last, (r_state == S_EMIT) && (n_state == S_IDLE), i_sts.last_row, "column ended before the last row")
    `GRC_ASSERT_NEXT(a_accept_div, (r_state == S_IDLE) && i_valid, (r_state == S_DIVA) && !i_sts.div_done, "transfer did not start the divider")

endmodule
